/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assertion macros
// shared checking macros for the locker bank rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check on every rising clock edge, masked while reset is active
`define ASSERT_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// check on every rising clock edge, reset included
`define ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) (prop)) \
    else $error("assertion failed");

`endif

/* rtl/clbac_pkg.sv */
// ----------------------------------------------------------------------------
// clbac_pkg
// types, widths and helpers for the card locker bank controller
// ----------------------------------------------------------------------------
package clbac_pkg;

  localparam int unsigned NUM_LOCKERS_DEF = 3;
  localparam int unsigned UID_BYTES       = 7;
  localparam int unsigned UID_W           = 56;
  localparam int unsigned LEN_W           = 3;
  localparam int unsigned SEL_W           = 4;
  localparam int unsigned CNT_W           = 16;
  localparam logic [CNT_W-1:0] COOLDOWN_RST = 16'd1000;
  localparam logic [CNT_W-1:0] CNT_MAX      = '1;

  // result codes
  typedef enum logic [2:0] {
    OC_TICK     = 3'd0,
    OC_BUSY     = 3'd1,
    OC_LOCKED   = 3'd2,
    OC_UNLOCKED = 3'd3,
    OC_DENIED   = 3'd4
  } outcome_e;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  // result item, locker_out in the low bits
  typedef struct packed {
    logic             lock_drive;
    outcome_e         outcome;
    logic [SEL_W-1:0] locker_out;
  } result_t;

  // keep only the first len bytes of a uid
  function automatic logic [UID_W-1:0] uid_mask(input logic [LEN_W-1:0] len);
    logic [UID_W-1:0] m;
    m = '0;
    for (int b = 0; b < UID_W / 8; b++) begin
      if (LEN_W'(b) < len) m[b*8 +: 8] = 8'hFF;
    end
    return m;
  endfunction

endpackage

/* rtl/card_locker_bank_access_control.sv */
// ----------------------------------------------------------------------------
// card_locker_bank_access_control
// card assignment, release and cooldown control for a bank of lockers
// ----------------------------------------------------------------------------
// Usage:
//   input stream s_axis: tuser = 0 is a tick, tuser = 1 a card at a locker;
//   tdata carries locker_sel, card_uid_len and card_uid.
//   output stream m_axis: one result item per input item (locker, outcome,
//   lock_drive), in input order.
//   cfg_wr_en_i / cfg_wr_data_i write the cooldown length in ticks; write
//   only while no item is in flight.
// Timing:
//   after acceptance a sequencer walks the lockers one per cycle through a
//   single compare / counter unit, then decides in the done state once the
//   output register is free, and the decision is written to the result
//   register; the next item is taken only once the sequencer is back in idle,
//   so a new item is not taken before the last one has left the done state.
// Reset:
//   all lockers unassigned and idle, cooldown length 1000, no result pending.
// Stall:
//   a result waits in the output register; a new item is still taken, but its
//   decision waits until the output register is free.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module card_locker_bank_access_control
  import clbac_pkg::*;
#(
  parameter int unsigned NUM_LOCKERS = NUM_LOCKERS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config
  input  logic              cfg_wr_en_i,
  input  logic [CNT_W-1:0]  cfg_wr_data_i,   // cooldown_ticks
  // input items
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [63:0] s_axis_tdata_i,        // locker_sel[3:0], card_uid_len[6:4],
                                             // card_uid[62:7], zero[63]
  input  logic        s_axis_tuser_i,        // func
  // result items
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o         // locker_out[3:0], outcome[6:4],
                                             // lock_drive[7]
);

  localparam int unsigned IDX_W = (NUM_LOCKERS > 1) ? $clog2(NUM_LOCKERS) : 1;

  // control and captured item
  state_e             state_q, state_d;
  logic [IDX_W-1:0]   scan_q;
  logic               func_q;
  logic [SEL_W-1:0]   sel_q;
  logic [LEN_W-1:0]   len_q;
  logic [UID_W-1:0]   uid_q;
  logic               dup_q, self_asg_q, self_cool_q, self_match_q;
  logic [CNT_W-1:0]   cool_ticks_q;
  logic               out_valid_q;
  result_t            out_q;

  // per locker state
  logic               asg_q   [NUM_LOCKERS];
  logic               cool_q  [NUM_LOCKERS];
  logic [CNT_W-1:0]   cnt_q   [NUM_LOCKERS];
  logic [UID_W-1:0]   suid_q  [NUM_LOCKERS];
  logic [LEN_W-1:0]   slen_q  [NUM_LOCKERS];

  // shared unit on the scanned locker
  logic               ent_asg, ent_cool, ent_eq, ent_self, ent_rel, scan_last;
  logic [CNT_W-1:0]   ent_cnt_inc;

  // decision
  logic               sel_ok, len_bad, do_lock, do_unlock, out_free, done_fire;
  result_t            res;
  logic               in_fire;

  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_q;

  // compare and count unit, one locker per cycle
  always_comb begin
    ent_asg     = asg_q[scan_q];
    ent_cool    = cool_q[scan_q];
    ent_eq      = (slen_q[scan_q] == len_q) && (suid_q[scan_q] == uid_q);
    ent_self    = (SEL_W'(scan_q) == sel_q);
    ent_cnt_inc = (cnt_q[scan_q] == CNT_MAX) ? cnt_q[scan_q] : cnt_q[scan_q] + 1'b1;
    ent_rel     = (ent_cnt_inc >= cool_ticks_q);
    scan_last   = (scan_q == IDX_W'(NUM_LOCKERS - 1));
  end

  // final decision for the captured item
  always_comb begin
    sel_ok    = ({1'b0, sel_q} < (SEL_W + 1)'(NUM_LOCKERS));
    len_bad   = (len_q == '0) || ({1'b0, len_q} > (LEN_W + 1)'(UID_BYTES));
    do_lock   = 1'b0;
    do_unlock = 1'b0;
    res.locker_out = sel_q;
    res.outcome    = OC_DENIED;
    res.lock_drive = self_asg_q;
    if (!func_q) begin
      res.locker_out = '0;
      res.outcome    = OC_TICK;
      res.lock_drive = 1'b0;
    end else if (!sel_ok) begin
      res.lock_drive = 1'b0;
    end else if (self_cool_q) begin
      res.outcome = OC_BUSY;
    end else if (len_bad) begin
      res.outcome = OC_DENIED;
    end else if (!self_asg_q) begin
      if (!dup_q) begin
        do_lock        = 1'b1;
        res.outcome    = OC_LOCKED;
        res.lock_drive = 1'b1;
      end
    end else if (self_match_q) begin
      do_unlock      = 1'b1;
      res.outcome    = OC_UNLOCKED;
      res.lock_drive = 1'b0;
    end
  end

  assign out_free  = !out_valid_q || m_axis_tready_i;
  assign done_fire = (state_q == ST_DONE) && out_free;

  // sequencer next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_fire) state_d = ST_SCAN;
      ST_SCAN: if (scan_last) state_d = ST_DONE;
      ST_DONE: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // control registers and item capture
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      scan_q       <= '0;
      cool_ticks_q <= COOLDOWN_RST;
      out_valid_q  <= 1'b0;
      dup_q        <= 1'b0;
      self_asg_q   <= 1'b0;
      self_cool_q  <= 1'b0;
      self_match_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_wr_en_i) cool_ticks_q <= cfg_wr_data_i;
      if (in_fire) begin
        scan_q       <= '0;
        dup_q        <= 1'b0;
        self_asg_q   <= 1'b0;
        self_cool_q  <= 1'b0;
        self_match_q <= 1'b0;
      end else if (state_q == ST_SCAN) begin
        if (!scan_last) scan_q <= scan_q + 1'b1;
        if (ent_self) begin
          self_asg_q   <= ent_asg;
          self_cool_q  <= ent_cool;
          self_match_q <= ent_eq;
        end else if (ent_asg && ent_eq) begin
          dup_q <= 1'b1;
        end
      end
      if (done_fire) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      func_q <= s_axis_tuser_i;
      sel_q  <= s_axis_tdata_i[3:0];
      len_q  <= s_axis_tdata_i[6:4];
      uid_q  <= s_axis_tdata_i[62:7] & uid_mask(s_axis_tdata_i[6:4]);
    end
    if (done_fire) out_q <= res;
  end

  // locker state: tick updates during the scan, card updates at the decision
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_LOCKERS; i++) begin
        asg_q[i]  <= 1'b0;
        cool_q[i] <= 1'b0;
        cnt_q[i]  <= '0;
        suid_q[i] <= '0;
        slen_q[i] <= '0;
      end
    end else begin
      for (int i = 0; i < NUM_LOCKERS; i++) begin
        if ((state_q == ST_SCAN) && !func_q && (scan_q == IDX_W'(i)) && ent_cool) begin
          cnt_q[i] <= ent_cnt_inc;
          if (ent_rel) cool_q[i] <= 1'b0;
        end
        if (done_fire && (sel_q == SEL_W'(i))) begin
          if (do_lock) begin
            asg_q[i]  <= 1'b1;
            suid_q[i] <= uid_q;
            slen_q[i] <= len_q;
            cool_q[i] <= 1'b1;
            cnt_q[i]  <= '0;
          end else if (do_unlock) begin
            asg_q[i]  <= 1'b0;
            suid_q[i] <= '0;
            slen_q[i] <= '0;
            cool_q[i] <= 1'b1;
            cnt_q[i]  <= '0;
          end
        end
      end
    end
  end

  // checks
  `ASSERT_CLK(a_scan_in_range, (state_q == ST_SCAN) |-> (scan_q < IDX_W'(NUM_LOCKERS - 1)) || scan_last)
  `ASSERT_CLK(a_accept_starts_scan, in_fire |=> (state_q == ST_SCAN) && (scan_q == '0))
  `ASSERT_CLK(a_new_result_from_done, $rose(out_valid_q) |-> $past(state_q) == ST_DONE)
  `ASSERT_CLK(a_locked_drives, (out_valid_q && (out_q.outcome == OC_LOCKED)) |-> out_q.lock_drive)
  `ASSERT_ALWAYS(a_reset_no_result, !rst_ni |=> !out_valid_q)

endmodule
